// ===== hw/rtl/rbca_pkg.sv =====
// Shared constants, result kinds and controller/datapath interface types.
`default_nettype none

package rbca_pkg;

  // Reorder window in packets; a power of two so a slot is the low seq bits.
  localparam int WINDOW = 16;
  localparam int SLOT_W = $clog2(WINDOW);

  localparam int SEQ_W  = 31;
  localparam int REF_W  = 16;
  localparam int LEN_W  = 11;
  localparam int ACK_W  = 32;
  localparam int KIND_W = 2;

  localparam int S_TDATA_W = 64;  // seq, ref, len = 58 bits, padded
  localparam int S_TUSER_W = 2;   // action, checksum_ok
  localparam int M_TDATA_W = 64;  // ref, len, ack = 59 bits, padded
  localparam int SLOT_DATA_W = REF_W + LEN_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_FINACK  = 2'd2
  } kind_e;

  // Commands from the controller; at most one emit per cycle.
  typedef struct packed {
    logic load;          // capture the incoming transaction
    logic emit_fin;      // FIN-ACK, close the block
    logic emit_in;       // deliver the captured packet, advance expected
    logic store;         // buffer the captured packet in its slot
    logic emit_rep_ack;  // repeat of the last ACK
    logic emit_drain;    // deliver the buffered packet at expected
    logic emit_cum_ack;  // cumulative ACK of expected-1
  } cmd_t;

  typedef struct packed {
    logic live;      // incoming transaction has good checksum, block open
    logic is_fin;    // captured packet is a FIN
    logic in_order;  // captured seq equals expected
    logic in_win;    // captured seq ahead of expected, inside the window
    logic slot_hit;  // slot at expected holds a buffered packet
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/reorder_buffer_cumulative_ack_receiver.sv =====
// Top level of the receive reorder buffer with cumulative ACK.
//
// Slave stream carries one received packet descriptor per transaction:
// tuser = {checksum_ok, action}, tdata = {len, ref, seq}. Master stream
// carries results: tuser = kind (deliver, ACK, FIN-ACK), tlast marks the
// final result of a packet. A bad checksum, or any packet after a FIN, is
// swallowed in the accept cycle with no result.
// Flow: one packet at a time, accepted and then classified; a FIN, buffered
// or dropped packet yields its single result at classification. An in-order
// packet delivers itself, then its buffered successors, one per cycle unless
// the master side stalls, limited by the single read port of the slot RAM.
// Results go through a one-deep output register; a stalled master side holds
// the sequencer in place, a new packet is still taken once the last result of
// the previous one sits in that register.
// Reset clears expected sequence to 0, last ACK to -1, all slot valid flags
// and the closed flag; slot RAM contents are not cleared and need no sweep.
`default_nettype none

module reorder_buffer_cumulative_ack_receiver
  import rbca_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output      logic                 s_axis_tready_o,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,  // seq_num, payload_ref, payload_len
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser_i,  // action, checksum_ok
  output      logic                 m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output      logic [M_TDATA_W-1:0] m_axis_tdata_o,  // out_ref, out_len, ack_num
  output      logic [KIND_W-1:0]    m_axis_tuser_o,  // kind
  output      logic                 m_axis_tlast_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: owns the transaction flow and result ordering.
  rbca_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // Datapath: sequence state, slot map and RAM, output register.
  rbca_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tready_i(m_axis_tready_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rbca_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rbca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rbca_datapath.sv =====
// Datapath: captured packet, sequence state, slot map, slot RAM, output register.
`default_nettype none

module rbca_datapath
  import rbca_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser_i,
  input  wire logic                 m_axis_tready_i,
  input  wire cmd_t                 cmd_i,
  output      sts_t                 sts_o,
  output      logic                 m_axis_tvalid_o,
  output      logic [M_TDATA_W-1:0] m_axis_tdata_o,
  output      logic [KIND_W-1:0]    m_axis_tuser_o,
  output      logic                 m_axis_tlast_o
);

  // captured transaction
  logic             act_q;
  logic [SEQ_W-1:0] seq_q;
  logic [REF_W-1:0] ref_q;
  logic [LEN_W-1:0] len_q;

  // sequence state
  logic [SEQ_W-1:0]  exp_q, exp_d;
  logic [ACK_W-1:0]  last_ack_q, last_ack_d;
  logic              closed_q;
  logic [WINDOW-1:0] slot_valid_q, slot_valid_d;

  // output register
  logic             ovalid_q;
  kind_e            okind_q;
  logic [REF_W-1:0] oref_q;
  logic [LEN_W-1:0] olen_q;
  logic [ACK_W-1:0] oack_q;
  logic             olast_q;

  logic [SEQ_W-1:0]       seq_diff;
  logic [SLOT_W-1:0]      exp_slot;
  logic [SLOT_W-1:0]      seq_slot;
  logic [SLOT_DATA_W-1:0] slot_rdata;
  logic [SEQ_W-1:0]       exp_m1;
  logic                   emit;

  assign exp_slot = exp_q[SLOT_W-1:0];
  assign seq_slot = seq_q[SLOT_W-1:0];
  assign seq_diff = seq_q - exp_q;
  assign exp_m1   = exp_q - SEQ_W'(1);
  assign emit     = cmd_i.emit_fin | cmd_i.emit_in | cmd_i.emit_rep_ack |
                    cmd_i.emit_drain | cmd_i.emit_cum_ack;

  always_comb begin
    sts_o.live     = s_axis_tuser_i[1] & ~closed_q;
    sts_o.is_fin   = act_q;
    sts_o.in_order = (seq_q == exp_q);
    sts_o.in_win   = (seq_q > exp_q) && (seq_diff < SEQ_W'(WINDOW));
    sts_o.slot_hit = slot_valid_q[exp_slot];
    sts_o.out_free = ~ovalid_q | m_axis_tready_i;
  end

  always_comb begin
    exp_d        = exp_q;
    last_ack_d   = last_ack_q;
    slot_valid_d = slot_valid_q;
    if (cmd_i.emit_in || cmd_i.emit_drain) begin
      exp_d = exp_q + SEQ_W'(1);
    end
    if (cmd_i.emit_drain) begin
      slot_valid_d[exp_slot] = 1'b0;
    end
    if (cmd_i.store) begin
      slot_valid_d[seq_slot] = 1'b1;
    end
    if (cmd_i.emit_cum_ack) begin
      last_ack_d = {1'b0, exp_m1};
    end
  end

  // Read address follows the next expected value so the data lines up with exp_q.
  rbca_ram #(
    .WIDTH(SLOT_DATA_W),
    .DEPTH(WINDOW)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(seq_slot),
    .wdata_i({ref_q, len_q}),
    .raddr_i(exp_d[SLOT_W-1:0]),
    .rdata_o(slot_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= s_axis_tuser_i[0];
      seq_q <= s_axis_tdata_i[SEQ_W-1:0];
      ref_q <= s_axis_tdata_i[SEQ_W+:REF_W];
      len_q <= s_axis_tdata_i[SEQ_W+REF_W+:LEN_W];
    end
    if (emit) begin
      okind_q <= KIND_ACK;
      oref_q  <= '0;
      olen_q  <= '0;
      oack_q  <= '0;
      olast_q <= 1'b1;
      if (cmd_i.emit_fin) begin
        okind_q <= KIND_FINACK;
      end else if (cmd_i.emit_in) begin
        okind_q <= KIND_DELIVER;
        oref_q  <= ref_q;
        olen_q  <= len_q;
        olast_q <= 1'b0;
      end else if (cmd_i.emit_drain) begin
        okind_q <= KIND_DELIVER;
        oref_q  <= slot_rdata[LEN_W+:REF_W];
        olen_q  <= slot_rdata[LEN_W-1:0];
        olast_q <= 1'b0;
      end else if (cmd_i.emit_cum_ack) begin
        oack_q  <= {1'b0, exp_m1};
      end else begin
        oack_q  <= last_ack_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q        <= '0;
      last_ack_q   <= '1;
      closed_q     <= 1'b0;
      slot_valid_q <= '0;
      ovalid_q     <= 1'b0;
    end else begin
      exp_q        <= exp_d;
      last_ack_q   <= last_ack_d;
      slot_valid_q <= slot_valid_d;
      if (cmd_i.emit_fin) begin
        closed_q <= 1'b1;
      end
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - REF_W - LEN_W - ACK_W){1'b0}},
                            oack_q, olen_q, oref_q};

  // A drain only ever reads a slot that holds a buffered packet.
  a_drain_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_drain |-> slot_valid_q[exp_slot])
    else $error("drain from a slot with no buffered packet");

  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |=> closed_q)
    else $error("closed flag cleared without reset");

  a_cum_ack_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_cum_ack |=> !last_ack_q[ACK_W-1])
    else $error("cumulative ack out of range");

  a_store_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> (sts_o.in_win && seq_slot != exp_slot))
    else $error("store outside the window");

endmodule

`default_nettype wire

// ===== hw/rtl/rbca_ctrl.sv =====
// Controller state machine: accept, classify, drain buffered slots, ACK.
`default_nettype none

module rbca_ctrl
  import rbca_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid_i,
  output      logic s_axis_tready_o,
  input  wire sts_t sts_i,
  output      cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DRAIN
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q, rdy_d;
  logic   accept;

  assign accept = s_axis_tvalid_i & rdy_q;

  always_comb begin
    state_d = state_q;
    rdy_d   = rdy_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = accept;
        if (accept && sts_i.live) begin
          state_d = S_EVAL;
          rdy_d   = 1'b0;
        end
      end
      S_EVAL: begin
        if (sts_i.out_free) begin
          if (sts_i.is_fin) begin
            cmd_o.emit_fin = 1'b1;
            state_d        = S_IDLE;
            rdy_d          = 1'b1;
          end else if (sts_i.in_order) begin
            cmd_o.emit_in = 1'b1;
            state_d       = S_DRAIN;
          end else begin
            cmd_o.store        = sts_i.in_win;
            cmd_o.emit_rep_ack = 1'b1;
            state_d            = S_IDLE;
            rdy_d              = 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if (sts_i.out_free) begin
          if (sts_i.slot_hit) begin
            cmd_o.emit_drain = 1'b1;
          end else begin
            cmd_o.emit_cum_ack = 1'b1;
            state_d            = S_IDLE;
            rdy_d              = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
        rdy_d   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      rdy_q   <= rdy_d;
    end
  end

  assign s_axis_tready_o = rdy_q;

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_fin || cmd_o.emit_in || cmd_o.emit_rep_ack ||
     cmd_o.emit_drain || cmd_o.emit_cum_ack) |-> sts_i.out_free)
    else $error("result issued while output register is full");

  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.emit_fin, cmd_o.emit_in, cmd_o.emit_rep_ack,
              cmd_o.emit_drain, cmd_o.emit_cum_ack}))
    else $error("more than one result issued in a cycle");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy_q |-> (state_q == S_IDLE))
    else $error("ready raised while a transaction is in progress");

endmodule

`default_nettype wire
